FILE: design/tab_respacing_filter_assert.svh
// Assertion macros for the tab re-spacing filter.
`ifndef TAB_RESPACING_FILTER_ASSERT_SVH
`define TAB_RESPACING_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tab re-spacing filter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tab re-spacing filter: next-cycle check failed");

`endif

FILE: design/trf_pkg.sv
// Shared constants, types and a helper function of the tab re-spacing filter.
`timescale 1ns / 1ps

package trf_pkg;

  localparam int COLUMN_BITS  = 16;
  localparam int MAX_TAB_SIZE = 16;
  localparam int SIZE_BITS    = $clog2(MAX_TAB_SIZE + 1);
  localparam int CNT_BITS     = $clog2(COLUMN_BITS);
  localparam int CFG_BITS     = 5;
  localparam int ADDR_BITS    = 4;
  localparam int DATA_BITS    = 32;

  typedef logic [COLUMN_BITS-1:0] trf_col_t;
  typedef logic [SIZE_BITS-1:0]   trf_size_t;

  localparam trf_col_t COL_MAX = '1;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  typedef enum logic [1:0] {
    REG_IN_TAB_SIZE,
    REG_OUT_TAB_SIZE,
    REG_PROC_DQUOTE,
    REG_PROC_SQUOTE
  } trf_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_IN,
    ST_DIV_OUT,
    ST_PREP,
    ST_FLUSH,
    ST_CHAR
  } trf_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } trf_div_status_t;

  function automatic trf_size_t clamp_size(input logic [CFG_BITS-1:0] v);
    trf_size_t s;
    if (v == '0) begin
      s = trf_size_t'(1);
    end else if (int'(v) > MAX_TAB_SIZE) begin
      s = trf_size_t'(MAX_TAB_SIZE);
    end else begin
      s = trf_size_t'(v);
    end
    return s;
  endfunction

endpackage

FILE: design/tab_respacing_filter.sv
// Top level of the tab re-spacing filter: registers, sequencer and output beat register.
// A space or tab outside a quote passes the prepare and flush states and may send gap beats.
// CR or LF goes straight on to the character state; any other byte first flushes its gap beats.
// After a tab size write, a column saturation or a quoted tab, the next byte first makes
// a pass of the bit-serial remainder unit for each affected column before it is processed.
// Reset clears the columns, the quote and the output beat and loads the register defaults.
`timescale 1ns / 1ps

`include "tab_respacing_filter_assert.svh"

module tab_respacing_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          run_last_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trf_pkg::ADDR_BITS-1:0] paddr,
  input  logic [trf_pkg::DATA_BITS-1:0] pwdata,
  output logic [trf_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);
  import trf_pkg::*;

  logic [CFG_BITS-1:0] in_tab_q, out_tab_q;
  logic                pdq_q, psq_q;
  logic                cfg_we;
  trf_reg_e            cfg_idx;

  trf_state_e          state_q, state_d;
  trf_col_t            in_col_q, in_col_d, out_col_q, out_col_d;
  trf_size_t           in_rem_q, in_rem_d, out_rem_q, out_rem_d;
  logic                in_ok_q, in_ok_d, out_ok_q, out_ok_d;
  logic [7:0]          quote_q, quote_d;
  logic [7:0]          ch_q, ch_d;
  logic                path_a_q, path_a_d;

  logic                out_valid_q;
  logic [7:0]          out_byte_q;
  logic                out_last_q;
  logic                emit, emit_last;
  logic [7:0]          emit_byte;

  logic                div_start;
  trf_col_t            div_col;
  trf_size_t           div_size, div_rem;
  trf_div_status_t     div_st;
  logic                div_phase;

  trf_size_t           isz, osz, d, width, in_rem_inc, out_rem_inc, in_rem_adv;
  trf_col_t            gap, d_ext, in_new;
  logic [COLUMN_BITS:0] in_sum;
  logic                in_sat, d_gt_gap, last_b, can_emit;
  logic                ch_blank, ch_crlf, ch_tab, ch_print;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = trf_reg_e'(paddr[ADDR_BITS-1:2]);

  always_comb begin
    case (cfg_idx)
      REG_IN_TAB_SIZE:  prdata = DATA_BITS'(in_tab_q);
      REG_OUT_TAB_SIZE: prdata = DATA_BITS'(out_tab_q);
      REG_PROC_DQUOTE:  prdata = DATA_BITS'(pdq_q);
      REG_PROC_SQUOTE:  prdata = DATA_BITS'(psq_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tab_q  <= CFG_BITS'(8);
      out_tab_q <= '0;
      pdq_q     <= 1'b0;
      psq_q     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_IN_TAB_SIZE:  in_tab_q  <= pwdata[CFG_BITS-1:0];
        REG_OUT_TAB_SIZE: out_tab_q <= pwdata[CFG_BITS-1:0];
        REG_PROC_DQUOTE:  pdq_q     <= pwdata[0];
        REG_PROC_SQUOTE:  psq_q     <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  trf_rem_unit u_rem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .col_i    (div_col),
    .size_i   (div_size),
    .rem_o    (div_rem),
    .status_o (div_st)
  );

  always_comb begin
    isz      = clamp_size(in_tab_q);
    osz      = (out_tab_q == '0) ? isz : clamp_size(out_tab_q);
    gap      = in_col_q - out_col_q;
    d        = osz - out_rem_q;
    d_ext    = COLUMN_BITS'(d);
    d_gt_gap = d_ext > gap;
    last_b   = (gap - d_ext) < COLUMN_BITS'(osz);
    can_emit = !out_valid_q || out_ready_i;

    ch_tab   = ch_q == CH_TAB;
    ch_blank = (ch_q == CH_SPACE) || ch_tab;
    ch_crlf  = (ch_q == CH_LF) || (ch_q == CH_CR);
    ch_print = ch_q >= CH_SPACE;

    if (ch_print) begin
      width = trf_size_t'(1);
    end else if (ch_tab) begin
      width = isz - in_rem_q;
    end else begin
      width = '0;
    end
    in_sum = {1'b0, in_col_q} + (COLUMN_BITS + 1)'(width);
    in_sat = in_sum[COLUMN_BITS];
    in_new = in_sat ? COL_MAX : in_sum[COLUMN_BITS-1:0];

    in_rem_inc = in_rem_q + 1'b1;
    if (in_rem_inc == isz) begin
      in_rem_inc = '0;
    end
    out_rem_inc = out_rem_q + 1'b1;
    if (out_rem_inc == osz) begin
      out_rem_inc = '0;
    end
    if (ch_tab) begin
      in_rem_adv = '0;
    end else if (ch_print) begin
      in_rem_adv = in_rem_inc;
    end else begin
      in_rem_adv = in_rem_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_col_d   = in_col_q;
    out_col_d  = out_col_q;
    in_rem_d   = in_rem_q;
    out_rem_d  = out_rem_q;
    in_ok_d    = in_ok_q;
    out_ok_d   = out_ok_q;
    quote_d    = quote_q;
    ch_d       = ch_q;
    path_a_d   = path_a_q;
    in_ready_o = 1'b0;
    emit       = 1'b0;
    emit_last  = 1'b0;
    emit_byte  = ch_q;
    div_start  = 1'b0;
    div_col    = in_col_q;
    div_size   = isz;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ch_d = in_byte_i;
          if (!in_ok_q) begin
            state_d = ST_DIV_IN;
          end else if (!out_ok_q) begin
            state_d = ST_DIV_OUT;
          end else begin
            state_d = ST_PREP;
          end
        end
      end
      ST_DIV_IN: begin
        div_start = !div_st.busy && !div_st.done;
        if (div_st.done) begin
          in_rem_d = div_rem;
          in_ok_d  = 1'b1;
          state_d  = out_ok_q ? ST_PREP : ST_DIV_OUT;
        end
      end
      ST_DIV_OUT: begin
        div_col   = out_col_q;
        div_size  = osz;
        div_start = !div_st.busy && !div_st.done;
        if (div_st.done) begin
          out_rem_d = div_rem;
          out_ok_d  = 1'b1;
          state_d   = ST_PREP;
        end
      end
      ST_PREP: begin
        if (ch_crlf) begin
          in_col_d  = '0;
          out_col_d = '0;
          in_rem_d  = '0;
          out_rem_d = '0;
          in_ok_d   = 1'b1;
          out_ok_d  = 1'b1;
          quote_d   = '0;
          state_d   = ST_CHAR;
        end else if ((quote_q != '0) || !ch_blank) begin
          path_a_d = 1'b1;
          state_d  = ST_FLUSH;
        end else begin
          path_a_d = 1'b0;
          in_col_d = in_new;
          in_rem_d = in_rem_adv;
          if (in_sat) begin
            in_ok_d = 1'b0;
          end
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (path_a_q) begin
          if (gap == '0) begin
            state_d = ST_CHAR;
          end else if (can_emit) begin
            emit = 1'b1;
            if (d_gt_gap) begin
              emit_byte = CH_SPACE;
              out_col_d = out_col_q + 1'b1;
              out_rem_d = out_rem_q + 1'b1;
            end else begin
              emit_byte = (d == trf_size_t'(1)) ? CH_SPACE : CH_TAB;
              out_col_d = out_col_q + d_ext;
              out_rem_d = '0;
            end
          end
        end else begin
          if ((gap == '0) || d_gt_gap) begin
            state_d = ST_IDLE;
          end else if (can_emit) begin
            emit      = 1'b1;
            emit_last = last_b;
            emit_byte = (d == trf_size_t'(1)) ? CH_SPACE : CH_TAB;
            out_col_d = out_col_q + d_ext;
            out_rem_d = '0;
            if (last_b) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_CHAR: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_byte = ch_q;
          in_col_d  = in_new;
          out_col_d = in_new;
          in_rem_d  = in_rem_adv;
          out_rem_d = ch_print ? out_rem_inc : out_rem_q;
          if (ch_tab || in_sat) begin
            out_ok_d = 1'b0;
          end
          if (in_sat) begin
            in_ok_d = 1'b0;
          end
          if (ch_q == quote_q) begin
            quote_d = '0;
          end else if (((ch_q == CH_DQUOTE) && !pdq_q) || ((ch_q == CH_SQUOTE) && !psq_q)) begin
            quote_d = ch_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we && ((cfg_idx == REG_IN_TAB_SIZE) || (cfg_idx == REG_OUT_TAB_SIZE))) begin
      in_ok_d  = 1'b0;
      out_ok_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      in_col_q  <= '0;
      out_col_q <= '0;
      in_rem_q  <= '0;
      out_rem_q <= '0;
      in_ok_q   <= 1'b1;
      out_ok_q  <= 1'b1;
      quote_q   <= '0;
      path_a_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      in_col_q  <= in_col_d;
      out_col_q <= out_col_d;
      in_rem_q  <= in_rem_d;
      out_rem_q <= out_rem_d;
      in_ok_q   <= in_ok_d;
      out_ok_q  <= out_ok_d;
      quote_q   <= quote_d;
      path_a_q  <= path_a_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = out_last_q;

  assign div_phase = (state_q == ST_DIV_IN) || (state_q == ST_DIV_OUT);

  `TRF_ASSERT_NOW(a_out_col_le_in_col, clk_i, rst_ni, 1'b1, out_col_q <= in_col_q)
  `TRF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `TRF_ASSERT_NOW(a_rem_done_in_div, clk_i, rst_ni, div_st.done, div_phase)

endmodule

FILE: design/trf_rem_unit.sv
// Bit-serial remainder unit: a column modulo a tab size, one column bit per cycle.
`timescale 1ns / 1ps

module trf_rem_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  trf_pkg::trf_col_t        col_i,
  input  trf_pkg::trf_size_t       size_i,
  output trf_pkg::trf_size_t       rem_o,
  output trf_pkg::trf_div_status_t status_o
);
  import trf_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  trf_col_t            shift_q, shift_d;
  trf_size_t           size_q, size_d;
  trf_size_t           rem_q, rem_d;
  logic [SIZE_BITS:0]  part;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    size_d  = size_q;
    rem_d   = rem_q;
    part    = {rem_q, shift_q[COLUMN_BITS-1]};
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      shift_d = col_i;
      size_d  = size_i;
      rem_d   = '0;
    end else if (busy_q) begin
      if (part >= {1'b0, size_q}) begin
        rem_d = SIZE_BITS'(part - {1'b0, size_q});
      end else begin
        rem_d = part[SIZE_BITS-1:0];
      end
      shift_d = shift_q << 1;
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == CNT_BITS'(COLUMN_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    size_q  <= size_d;
    rem_q   <= rem_d;
  end

  assign rem_o           = rem_q;
  assign status_o.busy   = busy_q;
  assign status_o.done   = done_q;

endmodule
